>>> hdl/fca_pkg.sv
// shared types and constants of the 3d frame change block
// no dependencies; imported by every module of the block
package fca_pkg;

  localparam int DATA_W    = 48;  // signed Q32.16 word
  localparam int FRAC_W    = 16;
  localparam int VEC_W     = DATA_W + 1;  // exact point difference
  localparam int NUM_COEFS = 12;
  localparam int COEF_IDX_W = 4;
  localparam int TRANS_BASE = 9;  // translation x,y,z follow the 3x3 matrix
  localparam int PROD_W    = 97;  // exact 48 x 49 signed product
  localparam int ACC_W     = 99;  // three products plus translation

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [NUM_COEFS-1:0][DATA_W-1:0] frame_t;
  typedef logic [2:0][DATA_W-1:0] tri_t;
  typedef logic [2:0][VEC_W-1:0] dtri_t;

  typedef struct packed {
    logic is_load;
    logic vec;
    logic src_none;
    logic dst_none;
    logic same;
  } meta_t;

endpackage

>>> hdl/fca_frame_mem.sv
// frame table: one bank per coefficient, one write port, two registered reads
// depends on fca_pkg
module fca_frame_mem import fca_pkg::*; #(
  parameter int FRAME_SLOTS = 4
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [$clog2(FRAME_SLOTS > 1 ? FRAME_SLOTS : 2)-1:0] wr_slot_i,
  input  logic [COEF_IDX_W-1:0] wr_idx_i,
  input  logic [DATA_W-1:0]     wr_data_i,
  input  logic                  rd_en_i,
  input  logic [$clog2(FRAME_SLOTS > 1 ? FRAME_SLOTS : 2)-1:0] rd_a_i,
  input  logic [$clog2(FRAME_SLOTS > 1 ? FRAME_SLOTS : 2)-1:0] rd_b_i,
  output frame_t                rd_a_o,
  output frame_t                rd_b_o
);

  logic [DATA_W-1:0] bank_q [NUM_COEFS][FRAME_SLOTS];
  frame_t rd_a_q, rd_b_q;

  // write one coefficient, read whole source and target frames
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bank_q[wr_idx_i][wr_slot_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      for (int c = 0; c < NUM_COEFS; c++) begin
        rd_a_q[c] <= bank_q[c][rd_a_i];
        rd_b_q[c] <= bank_q[c][rd_b_i];
      end
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

>>> hdl/fca_lane.sv
// one output component: 3-term dot product plus translation, round, saturate
// four stages; depends on fca_pkg
module fca_lane import fca_pkg::*; (
  input  logic                     clk_i,
  input  logic [3:0]               en_i,
  input  tri_t                     coef_i,
  input  dtri_t                    vec_i,
  input  logic signed [DATA_W-1:0] tr_i,
  output logic [DATA_W-1:0]        res_o,
  output logic                     sat_o
);

  logic signed [48:0] hh_q [3];
  logic signed [48:0] hl_q [3];
  logic signed [49:0] lh_q [3];
  logic [47:0]        ll_q [3];
  logic signed [DATA_W-1:0] tr1_q, tr2_q;
  logic signed [PROD_W-1:0] prod_q [3];
  logic signed [ACC_W-1:0]  acc_q;
  logic [DATA_W-1:0] res_q;
  logic sat_q;
  logic fits;

  // stage 1: split each product into four narrow partials
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < 3; j++) begin
        hh_q[j] <= $signed(coef_i[j][47:24]) * $signed(vec_i[j][48:24]);
        hl_q[j] <= $signed(coef_i[j][47:24]) * $signed({1'b0, vec_i[j][23:0]});
        lh_q[j] <= $signed({1'b0, coef_i[j][23:0]}) * $signed(vec_i[j][48:24]);
        ll_q[j] <= coef_i[j][23:0] * vec_i[j][23:0];
      end
      tr1_q <= tr_i;
    end
  end

  // stage 2: recombine partials into exact products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= (PROD_W'(hh_q[j]) <<< 48) + (PROD_W'(hl_q[j]) <<< 24)
                   + (PROD_W'(lh_q[j]) <<< 24) + PROD_W'($signed({1'b0, ll_q[j]}));
      end
      tr2_q <= tr1_q;
    end
  end

  // stage 3: dot product sum with translation and rounding half
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      acc_q <= ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2])
             + (ACC_W'(tr2_q) <<< FRAC_W) + RND_HALF;
    end
  end

  // stage 4: drop fraction and saturate to 48 bits
  assign fits = (&acc_q[ACC_W-1:DATA_W+FRAC_W-1]) | ~(|acc_q[ACC_W-1:DATA_W+FRAC_W-1]);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res_q <= fits ? acc_q[DATA_W+FRAC_W-1:FRAC_W] : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);
      sat_q <= ~fits;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

>>> hdl/frame_change_affine_3d.sv
// top level of the 3d rigid frame change: frame table, source and target lanes
// depends on fca_pkg, fca_frame_mem, fca_lane
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | operation, slot, coef, x/y/z, flags, frames
//  out     | output    | out_valid_o/out_ready_i | x/y/z_out_o, overflow_o
//
// one transaction per cycle while out_ready_i stays high; stages: table read, four
// source lane stages, difference stage, four target lane stages, output register
// each lane cuts its 48x49 products into four partials, which sets the depth
// reset clears only the stage valid bits; the frame table holds no reset value
// a stalled output backs up stage by stage, bubbles are squeezed out before
// in_ready_o drops
module frame_change_affine_3d import fca_pkg::*; #(
  parameter int FRAME_SLOTS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [1:0]        frame_slot_i,
  input  logic [3:0]        coef_index_i,
  input  logic [DATA_W-1:0] coef_value_i,
  input  logic [DATA_W-1:0] x_in_i,
  input  logic [DATA_W-1:0] y_in_i,
  input  logic [DATA_W-1:0] z_in_i,
  input  logic              is_vector_i,
  input  logic [2:0]        source_frame_i,
  input  logic [2:0]        target_frame_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] x_out_o,
  output logic [DATA_W-1:0] y_out_o,
  output logic [DATA_W-1:0] z_out_o,
  output logic              overflow_o
);

  localparam int SLOT_W = $clog2(FRAME_SLOTS > 1 ? FRAME_SLOTS : 2);

  logic [10:0] v_q;
  logic [11:0] en;
  logic in_acc, wr_en;
  meta_t meta_d;
  meta_t meta_q [11];
  tri_t  rin_q [10];
  frame_t src_fr, dst_fr;
  frame_t dfr_q [1:4];
  frame_t dfr5_q;
  tri_t  r_q [5:9];
  logic  ovf_q [5:9];
  dtri_t d5_q;
  tri_t  src_coef [3], tgt_coef [3];
  dtri_t rin_ext;
  logic [DATA_W-1:0] src_tr [3];
  logic [DATA_W-1:0] src_res [3], tgt_res [3];
  logic [2:0] src_sat, tgt_sat;
  tri_t  r_sel;
  dtri_t d_sel;
  logic  ovf_sel;
  tri_t  out_d, out_q;
  logic  ovf_d, ovf_out_q;

  // stage enables: a stage moves when it is empty or its successor moves
  always_comb begin
    en[11] = out_ready_i;
    for (int k = 10; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign in_acc     = in_valid_i & in_ready_o;
  assign wr_en      = in_acc & (operation_i == OP_LOAD) & (32'(frame_slot_i) < FRAME_SLOTS)
                    & (coef_index_i < COEF_IDX_W'(NUM_COEFS));

  // transaction decode
  always_comb begin
    meta_d.is_load  = (operation_i == OP_LOAD);
    meta_d.vec      = is_vector_i;
    meta_d.src_none = (32'(source_frame_i) >= FRAME_SLOTS);
    meta_d.dst_none = (32'(target_frame_i) >= FRAME_SLOTS);
    meta_d.same     = (meta_d.src_none & meta_d.dst_none)
                    | (~meta_d.src_none & ~meta_d.dst_none & (source_frame_i == target_frame_i));
  end

  fca_frame_mem #(.FRAME_SLOTS(FRAME_SLOTS)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_slot_i (SLOT_W'(frame_slot_i)),
    .wr_idx_i  (coef_index_i),
    .wr_data_i (coef_value_i),
    .rd_en_i   (en[0]),
    .rd_a_i    (SLOT_W'(source_frame_i)),
    .rd_b_i    (SLOT_W'(target_frame_i)),
    .rd_a_o    (src_fr),
    .rd_b_o    (dst_fr)
  );

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k <= 10; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // side payload carried along the pipeline
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      meta_q[0] <= meta_d;
      rin_q[0]  <= {z_in_i, y_in_i, x_in_i};
    end
    for (int k = 1; k <= 10; k++) begin
      if (en[k]) meta_q[k] <= meta_q[k-1];
    end
    for (int k = 1; k <= 9; k++) begin
      if (en[k]) rin_q[k] <= rin_q[k-1];
    end
    if (en[1]) dfr_q[1] <= dst_fr;
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) dfr_q[k] <= dfr_q[k-1];
    end
    for (int k = 6; k <= 9; k++) begin
      if (en[k]) begin
        r_q[k]   <= r_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // source lanes: rows of the source matrix, translation for points
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rin_ext[i] = {rin_q[0][i][DATA_W-1], rin_q[0][i]};
      src_tr[i]  = meta_q[0].vec ? '0 : src_fr[TRANS_BASE+i];
      for (int j = 0; j < 3; j++) begin
        src_coef[i][j] = src_fr[i*3+j];
        tgt_coef[i][j] = dfr5_q[j*3+i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_src
    fca_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[4:1]),
      .coef_i (src_coef[i]),
      .vec_i  (rin_ext),
      .tr_i   ($signed(src_tr[i])),
      .res_o  (src_res[i]),
      .sat_o  (src_sat[i])
    );
  end

  // merge source result, form target difference
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r_sel[j] = meta_q[4].src_none ? rin_q[4][j] : src_res[j];
      d_sel[j] = meta_q[4].vec ? VEC_W'($signed(r_sel[j]))
               : VEC_W'($signed(r_sel[j])) - VEC_W'($signed(dfr_q[4][TRANS_BASE+j]));
    end
    ovf_sel = ~meta_q[4].src_none & (|src_sat);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      r_q[5]   <= r_sel;
      d5_q     <= d_sel;
      ovf_q[5] <= ovf_sel;
      dfr5_q   <= dfr_q[4];
    end
  end

  // target lanes: columns of the target matrix, transpose product
  for (genvar i = 0; i < 3; i++) begin : g_tgt
    fca_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[9:6]),
      .coef_i (tgt_coef[i]),
      .vec_i  (d5_q),
      .tr_i   ('0),
      .res_o  (tgt_res[i]),
      .sat_o  (tgt_sat[i])
    );
  end

  // final selection into the output register
  always_comb begin
    priority if (meta_q[9].is_load) begin
      out_d = '0;
      ovf_d = 1'b0;
    end else if (meta_q[9].same) begin
      out_d = rin_q[9];
      ovf_d = 1'b0;
    end else if (meta_q[9].dst_none) begin
      out_d = r_q[9];
      ovf_d = ovf_q[9];
    end else begin
      out_d = {tgt_res[2], tgt_res[1], tgt_res[0]};
      ovf_d = ovf_q[9] | (|tgt_sat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      out_q     <= out_d;
      ovf_out_q <= ovf_d;
    end
  end

  assign out_valid_o = v_q[10];
  assign x_out_o     = out_q[0];
  assign y_out_o     = out_q[1];
  assign z_out_o     = out_q[2];
  assign overflow_o  = ovf_out_q;

`ifndef ASSERT_OFF
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[10] && meta_q[10].is_load |-> out_q == '0 && !ovf_out_q)
    else $error("load transaction produced nonzero result");

  a_same_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[10] && meta_q[10].same |-> !ovf_out_q)
    else $error("pass-through transaction flagged overflow");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && (&v_q))
    else $error("input stalled while pipeline has a bubble");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] && !en[5] |=> v_q[5])
    else $error("stalled stage lost its transaction");
`endif

endmodule

>>> tb/tb.sv
// self-checking testbench for frame_change_affine_3d
// depends on fca_pkg and the block's rtl; predicts each result in place
`timescale 1ns / 100ps

module tb import fca_pkg::*;;

  localparam int SLOTS      = 4;
  localparam int NONE_FRAME = SLOTS;
  localparam int LATENCY    = 11;
  localparam int N_RANDOM   = 1200;
  localparam int MAX_CYCLES = 400000;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic       op;
    logic [1:0] slot;
    logic [3:0] idx;
    word_t      coef;
    word_t      x;
    word_t      y;
    word_t      z;
    logic       vec;
    logic [2:0] src;
    logic [2:0] dst;
  } xact_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  ovf;
  } coord_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = OP_LOAD;
  logic [1:0] frame_slot_i = '0;
  logic [3:0] coef_index_i = '0;
  logic [DATA_W-1:0] coef_value_i = '0, x_in_i = '0, y_in_i = '0, z_in_i = '0;
  logic is_vector_i = 1'b0;
  logic [2:0] source_frame_i = '0, target_frame_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DATA_W-1:0] x_out_o, y_out_o, z_out_o;
  logic overflow_o;

  frame_change_affine_3d #(.FRAME_SLOTS(SLOTS)) dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow frame table and bookkeeping
  word_t frame_tab [SLOTS][NUM_COEFS];
  xact_t pending_q[$];
  coord_res_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit stim_done = 1'b0;
  int hold_off = 0;

  // round a Q.32 sum to Q.16 with ties upward, saturate to 48 bits
  function automatic word_t round_sat(logic signed [ACC_W-1:0] acc, ref logic ovf);
    logic signed [ACC_W-1:0] h;
    h = (acc + RND_HALF) >>> FRAC_W;
    if (h > $signed({{(ACC_W-DATA_W){1'b0}}, SAT_MAX})) begin
      ovf = 1'b1;
      return word_t'(SAT_MAX);
    end
    if (h < $signed({{(ACC_W-DATA_W){1'b1}}, SAT_MIN})) begin
      ovf = 1'b1;
      return word_t'(SAT_MIN);
    end
    return h[DATA_W-1:0];
  endfunction

  // frame change of one transaction, updates the shadow table on loads
  function automatic coord_res_t frame_change(xact_t t);
    coord_res_t res;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] r [3];
    word_t q [3];
    logic ovf;
    int s, d;
    res = '0;
    if (t.op == OP_LOAD) begin
      if (t.idx < NUM_COEFS) begin
        frame_tab[t.slot][t.idx] = t.coef;
      end
      return res;
    end
    ovf = 1'b0;
    r[0] = ACC_W'(t.x); r[1] = ACC_W'(t.y); r[2] = ACC_W'(t.z);
    s = (t.src > NONE_FRAME) ? NONE_FRAME : int'(t.src);
    d = (t.dst > NONE_FRAME) ? NONE_FRAME : int'(t.dst);
    if (s != d) begin
      if (s < SLOTS) begin
        for (int i = 0; i < 3; i++) begin
          acc = t.vec ? '0 : (ACC_W'(frame_tab[s][TRANS_BASE+i]) <<< FRAC_W);
          for (int j = 0; j < 3; j++) acc += ACC_W'(frame_tab[s][i*3+j]) * r[j];
          q[i] = round_sat(acc, ovf);
        end
        for (int i = 0; i < 3; i++) r[i] = ACC_W'(q[i]);
      end
      if (d < SLOTS) begin
        for (int j = 0; j < 3; j++)
          if (!t.vec) r[j] = r[j] - ACC_W'(frame_tab[d][TRANS_BASE+j]);
        for (int i = 0; i < 3; i++) begin
          acc = '0;
          for (int j = 0; j < 3; j++) acc += ACC_W'(frame_tab[d][j*3+i]) * r[j];
          q[i] = round_sat(acc, ovf);
        end
        for (int i = 0; i < 3; i++) r[i] = ACC_W'(q[i]);
      end
    end
    res.x = r[0][DATA_W-1:0];
    res.y = r[1][DATA_W-1:0];
    res.z = r[2][DATA_W-1:0];
    res.ovf = ovf;
    return res;
  endfunction

  function automatic word_t rand_word(int mode);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (mode)
      0: return word_t'($signed(v[19:0]));            // around +-8
      1: return word_t'(v);                           // anything
      2: return v[0] ? word_t'(SAT_MAX) : word_t'(SAT_MIN);
      default: return word_t'($signed(v[27:0]));      // moderate
    endcase
  endfunction

  function automatic xact_t load_x(int slot, int idx, word_t val);
    xact_t t;
    t = '0;
    t.op = OP_LOAD;
    t.slot = 2'(slot);
    t.idx = 4'(idx);
    t.coef = val;
    t.x = rand_word(1); t.y = rand_word(1); t.z = rand_word(1);
    return t;
  endfunction

  function automatic xact_t xform_x(word_t x, word_t y, word_t z, bit vec, int s, int d);
    xact_t t;
    t = '0;
    t.op = OP_XFORM;
    t.slot = 2'($urandom); t.idx = 4'($urandom); t.coef = rand_word(1);
    t.x = x; t.y = y; t.z = z; t.vec = vec; t.src = 3'(s); t.dst = 3'(d);
    return t;
  endfunction

  // pick a frame reference that never reads an unwritten slot
  function automatic int pick_frame(bit loaded [SLOTS]);
    int f;
    f = $urandom_range(0, 7);
    if (f < SLOTS && !loaded[f]) f = NONE_FRAME + $urandom_range(0, 3);
    return f;
  endfunction

  // stimulus
  initial begin
    bit loaded [SLOTS];
    int s, mode;
    for (int i = 0; i < SLOTS; i++) loaded[i] = 1'b0;
    // slot 0 identity rotation with a small offset
    for (int k = 0; k < NUM_COEFS; k++)
      pending_q.push_back(load_x(0, k, (k == 0 || k == 4 || k == 8) ? word_t'(1 << FRAC_W)
                                        : (k >= TRANS_BASE ? word_t'(k << FRAC_W) : '0)));
    loaded[0] = 1'b1;
    pending_q.push_back(load_x(0, 12, word_t'(SAT_MAX)));  // ignored index
    pending_q.push_back(load_x(0, 15, word_t'(SAT_MIN)));
    pending_q.push_back(xform_x(word_t'(SAT_MAX), word_t'(SAT_MIN), '0, 1'b0, 0, 4));
    pending_q.push_back(xform_x(word_t'(SAT_MAX), word_t'(SAT_MIN), word_t'(5), 1'b0, 4, 0));
    pending_q.push_back(xform_x(word_t'(SAT_MAX), word_t'(1), word_t'(2), 1'b1, 0, 4));
    // same frame passes through
    pending_q.push_back(xform_x(word_t'(3), word_t'(4), word_t'(5), 1'b0, 2, 2));
    // out-of-range means none
    pending_q.push_back(xform_x(word_t'(3), word_t'(4), word_t'(5), 1'b1, 7, 4));
    pending_q.push_back(xform_x(word_t'(-1), word_t'(-(1 << 15)), word_t'(1 << 15),
                                1'b0, 0, 6));
    // random phases: reload frames, then stream transforms
    for (int ph = 0; ph < 12; ph++) begin
      s = $urandom_range(0, SLOTS-1);
      mode = (ph % 4 == 3) ? 2 : ((ph % 4 == 2) ? 1 : 3);
      for (int k = 0; k < NUM_COEFS; k++) pending_q.push_back(load_x(s, k, rand_word(mode)));
      loaded[s] = 1'b1;
      if ($urandom_range(0, 1)) pending_q.push_back(load_x(s, 12 + $urandom_range(0, 3),
                                                           rand_word(1)));
      for (int n = 0; n < N_RANDOM / 12; n++)
        pending_q.push_back(xform_x(rand_word($urandom_range(0, 3)),
                                    rand_word($urandom_range(0, 3)),
                                    rand_word($urandom_range(0, 3)),
                                    1'($urandom), pick_frame(loaded), pick_frame(loaded)));
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    xact_t t;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        void'(pending_q.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > (in_valid_i && in_ready_o ? 1 : 0)) begin
          t = pending_q[(in_valid_i && in_ready_o) ? 1 : 0];
          in_valid_i <= 1'b1;
          operation_i <= t.op; frame_slot_i <= t.slot; coef_index_i <= t.idx;
          coef_value_i <= t.coef; x_in_i <= t.x; y_in_i <= t.y; z_in_i <= t.z;
          is_vector_i <= t.vec; source_frame_i <= t.src; target_frame_i <= t.dst;
          if ($urandom_range(0, 9) == 0)
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // predict on every accepted transaction
  always @(posedge clk_i) begin
    xact_t t;
    if (rst_ni && in_valid_i && in_ready_o) begin
      t.op = operation_i; t.slot = frame_slot_i; t.idx = coef_index_i;
      t.coef = coef_value_i; t.x = x_in_i; t.y = y_in_i; t.z = z_in_i;
      t.vec = is_vector_i; t.src = source_frame_i; t.dst = target_frame_i;
      expected_q.push_back(frame_change(t));
    end
  end

  // receiver backpressure, one long hold-off early in the random part
  bit long_done = 1'b0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (!long_done && cycles >= 300) begin
      long_done <= 1'b1;
      hold_off <= 200;
      out_ready_i <= 1'b0;
    end else if ((cycles / 500) % 3 == 0) begin
      out_ready_i <= 1'b1;  // stretch without stalls
    end else if ($urandom_range(0, 7) == 0) begin
      hold_off <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    coord_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h z=%h ovf=%b",
                                       x_out_o, y_out_o, z_out_o, overflow_o);
      end else begin
        e = expected_q.pop_front();
        if (x_out_o !== e.x || y_out_o !== e.y || z_out_o !== e.z ||
            overflow_o !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h ovf=%b got x=%h y=%h z=%h ovf=%b",
                     e.x, e.y, e.z, e.ovf, x_out_o, y_out_o, z_out_o, overflow_o);
        end
      end
    end
  end

  // end of run and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (expected_q.size() == 0);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fca_pkg.sv
hdl/fca_frame_mem.sv
hdl/fca_lane.sv
hdl/frame_change_affine_3d.sv
tb/tb.sv
